>>> hw/rtl/rkm_pkg.sv
// rkm_pkg: shared types and constants of the rotary knob menu controller
// used by rkm_next and rotary_knob_menu_controller; no dependencies
package rkm_pkg;

	localparam int INPUT_CHOICES_DEF = 4;
	localparam int MENU_ITEMS_DEF    = 5;

	localparam int CURSOR_W = 3;
	localparam int VSTEP_W  = 7;
	localparam int LPRESS_W = 16;
	localparam int TIME_W   = 32;
	localparam int VOL_W    = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [VSTEP_W-1:0]  VSTEP_RST  = 7'd2;
	localparam logic [LPRESS_W-1:0] LPRESS_RST = 16'd1000;
	localparam logic [VOL_W-1:0]    VOL_MAX    = 8'd255;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_STEP   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 8'd1;

	// event codes
	localparam logic [2:0] OP_LEFT    = 3'd0;
	localparam logic [2:0] OP_RIGHT   = 3'd1;
	localparam logic [2:0] OP_DOWN    = 3'd2;
	localparam logic [2:0] OP_UP      = 3'd3;
	localparam logic [2:0] OP_REFRESH = 3'd4;
	localparam logic [2:0] OP_POLL    = 3'd5;

	// menu modes
	localparam logic [1:0] MODE_VOLUME = 2'd1;
	localparam logic [1:0] MODE_INPUT  = 2'd2;
	localparam logic [1:0] MODE_MENU   = 2'd3;

	// settings menu items
	localparam logic [CURSOR_W-1:0] ITEM_AUTO_SWITCH = 3'd1;
	localparam logic [CURSOR_W-1:0] ITEM_HEADPHONES  = 3'd2;
	localparam logic [CURSOR_W-1:0] ITEM_SPEAKERS    = 3'd3;
	localparam logic [CURSOR_W-1:0] ITEM_AUTO_OFF    = 3'd4;

	// option flag bit positions
	localparam int F_AUTO = 0;
	localparam int F_HP   = 1;
	localparam int F_SP   = 2;
	localparam int F_OFF  = 3;

	typedef struct packed {
		logic [1:0]          mode;
		logic [CURSOR_W-1:0] cursor;
		logic [TIME_W-1:0]   press_time;
		logic [VOL_W-1:0]    volume;
		logic [1:0]          source;
		logic                mute;
		logic [3:0]          flags;
		logic                usb;
	} rkm_state_t;

	localparam rkm_state_t STATE_RST = '{
		mode: MODE_VOLUME, cursor: '0, press_time: '0, volume: '0,
		source: '0, mute: 1'b0, flags: '0, usb: 1'b0
	};

endpackage

>>> hw/rtl/rkm_next.sv
// rkm_next: next-state and notify/redraw logic for one knob event
// depends on rkm_pkg
module rkm_next #(
	parameter int INPUT_CHOICES = rkm_pkg::INPUT_CHOICES_DEF,
	parameter int MENU_ITEMS    = rkm_pkg::MENU_ITEMS_DEF
) (
	input  logic [rkm_pkg::VSTEP_W-1:0]  volume_step,
	input  logic [rkm_pkg::LPRESS_W-1:0] long_press_ms,
	input  logic [2:0]                   operation,
	input  logic [rkm_pkg::TIME_W-1:0]   now_ms,
	input  logic                         jack_inserted,
	input  logic                         usb_sense_low,
	input  rkm_pkg::rkm_state_t          cur,
	output rkm_pkg::rkm_state_t          nxt,
	output logic                         notify,
	output logic                         redraw
);
	import rkm_pkg::*;

	localparam logic [CURSOR_W-1:0] IN_LAST   = CURSOR_W'(INPUT_CHOICES - 1);
	localparam logic [CURSOR_W-1:0] MENU_LAST = CURSOR_W'(MENU_ITEMS - 1);
	localparam logic [CURSOR_W:0]   IN_N      = (CURSOR_W+1)'(INPUT_CHOICES);
	localparam logic [CURSOR_W:0]   MENU_N    = (CURSOR_W+1)'(MENU_ITEMS);

	logic [CURSOR_W:0]   cur_inc;
	logic [CURSOR_W-1:0] in_inc, in_dec, menu_inc, menu_dec;
	logic [VOL_W:0]      vol_up;
	logic [TIME_W-1:0]   held;
	logic [1:0]          want;

	always_comb begin
		cur_inc  = {1'b0, cur.cursor} + 1'b1;
		in_inc   = (cur_inc >= IN_N) ? CURSOR_W'(cur_inc - IN_N) : cur_inc[CURSOR_W-1:0];
		menu_inc = (cur_inc >= MENU_N) ? CURSOR_W'(cur_inc - MENU_N) : cur_inc[CURSOR_W-1:0];
		in_dec   = (cur.cursor == '0) ? IN_LAST : cur.cursor - 1'b1;
		menu_dec = (cur.cursor == '0) ? MENU_LAST : cur.cursor - 1'b1;
		vol_up   = {1'b0, cur.volume} + {2'b00, volume_step};
		held     = now_ms - cur.press_time;
		// {speakers, headphones} wanted by auto switch
		want     = jack_inserted ? 2'b01 : 2'b10;
	end

	always_comb begin
		nxt    = cur;
		notify = 1'b0;
		redraw = 1'b0;
		if (operation == OP_POLL) begin
			if (cur.flags[F_AUTO] && cur.flags[F_SP:F_HP] != want) begin
				nxt.flags[F_SP:F_HP] = want;
				notify = 1'b1;
			end
			if (cur.usb != usb_sense_low) begin
				nxt.usb = usb_sense_low;
				notify  = 1'b1;
			end
		end else if (operation <= OP_REFRESH) begin
			unique case (cur.mode)
				MODE_VOLUME: begin
					unique case (operation)
						OP_LEFT: begin
							nxt.volume = (cur.volume <= {1'b0, volume_step}) ? '0 :
								cur.volume - {1'b0, volume_step};
							notify = 1'b1;
							redraw = 1'b1;
						end
						OP_RIGHT: begin
							nxt.volume = (vol_up >= {1'b0, VOL_MAX}) ? VOL_MAX : vol_up[VOL_W-1:0];
							notify = 1'b1;
							redraw = 1'b1;
						end
						OP_DOWN: nxt.press_time = now_ms;
						OP_UP: begin
							if (held > {{(TIME_W-LPRESS_W){1'b0}}, long_press_ms}) begin
								nxt.mode   = MODE_MENU;
								nxt.cursor = '0;
							end else begin
								nxt.mode   = MODE_INPUT;
								notify     = !cur.mute;
								nxt.mute   = 1'b1;
								nxt.cursor = {1'b0, cur.source};
							end
							redraw = 1'b1;
						end
						default: redraw = 1'b1;
					endcase
				end
				MODE_INPUT: begin
					unique case (operation)
						OP_LEFT: begin
							nxt.cursor = in_dec;
							redraw = 1'b1;
						end
						OP_RIGHT: begin
							nxt.cursor = in_inc;
							redraw = 1'b1;
						end
						OP_UP: begin
							// last choice cancels and stays muted
							if (cur.cursor < IN_LAST) begin
								notify     = (cur.cursor[1:0] != cur.source) || cur.mute;
								nxt.source = cur.cursor[1:0];
								nxt.mute   = 1'b0;
							end
							nxt.mode = MODE_VOLUME;
							redraw   = 1'b1;
						end
						default: ;
					endcase
				end
				MODE_MENU: begin
					unique case (operation)
						OP_LEFT: begin
							nxt.cursor = menu_dec;
							redraw = 1'b1;
						end
						OP_RIGHT: begin
							nxt.cursor = menu_inc;
							redraw = 1'b1;
						end
						OP_UP: begin
							unique case (cur.cursor)
								ITEM_AUTO_SWITCH: nxt.flags[F_AUTO] = !cur.flags[F_AUTO];
								ITEM_HEADPHONES: begin
									nxt.flags[F_AUTO] = 1'b0;
									nxt.flags[F_HP]   = !cur.flags[F_HP];
								end
								ITEM_SPEAKERS: begin
									nxt.flags[F_AUTO] = 1'b0;
									nxt.flags[F_SP]   = !cur.flags[F_SP];
								end
								ITEM_AUTO_OFF: nxt.flags[F_OFF] = !cur.flags[F_OFF];
								default: ;
							endcase
							nxt.mode = MODE_VOLUME;
							redraw   = 1'b1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/rotary_knob_menu_controller.sv
// rotary_knob_menu_controller: knob event handler with volume, input select
// and settings menu; uses rkm_pkg and rkm_next
// path: the input register takes the request when it is accepted, then the state and
// result register takes the result; throughput one request per cycle unless a held
// result stalls the input, set by the single next-state pass. reset: volume mode, all
// settings cleared, volume_step 2, long_press_ms 1000, no result pending.
module rotary_knob_menu_controller #(
	parameter int INPUT_CHOICES = rkm_pkg::INPUT_CHOICES_DEF,
	parameter int MENU_ITEMS    = rkm_pkg::MENU_ITEMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rkm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rkm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      operation,
	input  logic [rkm_pkg::TIME_W-1:0]      now_ms,
	input  logic                            jack_inserted,
	input  logic                            usb_sense_low,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      ui_mode,
	output logic [rkm_pkg::CURSOR_W-1:0]    cursor,
	output logic [rkm_pkg::VOL_W-1:0]       volume,
	output logic [1:0]                      input_source,
	output logic                            muted,
	output logic                            auto_switch_on,
	output logic                            headphones_enabled,
	output logic                            speakers_enabled,
	output logic                            auto_off_on,
	output logic                            usb_powered,
	output logic                            notify,
	output logic                            redraw
);
	import rkm_pkg::*;

	logic [VSTEP_W-1:0]  volume_step_q;
	logic [LPRESS_W-1:0] long_press_q;

	logic                valid_s1;
	logic [2:0]          op_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                jack_s1;
	logic                usb_s1;

	rkm_state_t state_q, state_nxt;
	logic       notify_nxt, redraw_nxt, notify_q, redraw_q, out_valid_q;
	logic       out_busy, advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_step_q <= VSTEP_RST;
			long_press_q  <= LPRESS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_VOLUME_STEP)
				volume_step_q <= cfg_data[VSTEP_W-1:0];
			else if (cfg_index == CFG_LONG_PRESS_MS)
				long_press_q <= cfg_data[LPRESS_W-1:0];
		end
	end

	// result register parts the two sides; input register frees when it moves on
	assign out_busy = out_valid_q && out_stall;
	assign advance  = valid_s1 && !out_busy;
	assign in_stall = valid_s1 && out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			now_s1  <= now_ms;
			jack_s1 <= jack_inserted;
			usb_s1  <= usb_sense_low;
		end
	end

	rkm_next #(
		.INPUT_CHOICES(INPUT_CHOICES),
		.MENU_ITEMS   (MENU_ITEMS)
	) u_next (
		.volume_step  (volume_step_q),
		.long_press_ms(long_press_q),
		.operation    (op_s1),
		.now_ms       (now_s1),
		.jack_inserted(jack_s1),
		.usb_sense_low(usb_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.notify       (notify_nxt),
		.redraw       (redraw_nxt)
	);

	// state only moves with a new result, so it doubles as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			notify_q <= notify_nxt;
			redraw_q <= redraw_nxt;
		end
	end

	assign out_valid          = out_valid_q;
	assign ui_mode            = state_q.mode;
	assign cursor             = state_q.cursor;
	assign volume             = state_q.volume;
	assign input_source       = state_q.source;
	assign muted              = state_q.mute;
	assign auto_switch_on     = state_q.flags[F_AUTO];
	assign headphones_enabled = state_q.flags[F_HP];
	assign speakers_enabled   = state_q.flags[F_SP];
	assign auto_off_on        = state_q.flags[F_OFF];
	assign usb_powered        = state_q.usb;
	assign notify             = notify_q;
	assign redraw             = redraw_q;

endmodule

>>> bench/rotary_knob_menu_controller_test.sv
// rotary_knob_menu_controller_test: self-checking bench for the knob menu controller
// needs rkm_pkg and rotary_knob_menu_controller; the expected state after each knob
// event comes from a predictor kept inside this file
module rotary_knob_menu_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rkm_pkg::*;

	// the operation field has two codes that the block must ignore
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int QUIET_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_EVENTS  = 325;
	localparam int PHASES        = 6;
	localparam int PRINT_CAP     = 100;

	typedef struct {
		logic [2:0]        op;
		logic [TIME_W-1:0] stamp;
		logic              jack;
		logic              usb;
	} knob_event_t;

	typedef struct packed {
		logic [1:0]          mode;
		logic [CURSOR_W-1:0] cursor;
		logic [VOL_W-1:0]    volume;
		logic [1:0]          source;
		logic                muted;
		logic                auto_sw;
		logic                hp;
		logic                sp;
		logic                pwr_save;
		logic                usb;
		logic                notify;
		logic                redraw;
	} knob_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_VOLUME_STEP;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [2:0]            operation = OP_LEFT;
	logic [TIME_W-1:0]     now_ms = '0;
	logic                  jack_inserted = 1'b0;
	logic                  usb_sense_low = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            ui_mode;
	logic [CURSOR_W-1:0]   cursor;
	logic [VOL_W-1:0]      volume;
	logic [1:0]            input_source;
	logic                  muted;
	logic                  auto_switch_on;
	logic                  headphones_enabled;
	logic                  speakers_enabled;
	logic                  auto_off_on;
	logic                  usb_powered;
	logic                  notify;
	logic                  redraw;

	rotary_knob_menu_controller dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.operation          (operation),
		.now_ms             (now_ms),
		.jack_inserted      (jack_inserted),
		.usb_sense_low      (usb_sense_low),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.ui_mode            (ui_mode),
		.cursor             (cursor),
		.volume             (volume),
		.input_source       (input_source),
		.muted              (muted),
		.auto_switch_on     (auto_switch_on),
		.headphones_enabled (headphones_enabled),
		.speakers_enabled   (speakers_enabled),
		.auto_off_on        (auto_off_on),
		.usb_powered        (usb_powered),
		.notify             (notify),
		.redraw             (redraw)
	);

	always #5 clk = ~clk;

	// predicted knob state and settings
	logic [1:0]          k_mode = MODE_VOLUME;
	logic [CURSOR_W-1:0] k_cursor = '0;
	logic [TIME_W-1:0]   k_press = '0;
	logic [VOL_W-1:0]    k_volume = '0;
	logic [1:0]          k_source = '0;
	logic                k_mute = 1'b0;
	logic [3:0]          k_flags = '0;
	logic                k_usb = 1'b0;
	logic [VSTEP_W-1:0]  vol_step = VSTEP_RST;
	logic [LPRESS_W-1:0] long_press = LPRESS_RST;

	knob_event_t pending_events[$];
	knob_view_t  expected_views[$];
	knob_event_t next_ev;
	knob_view_t  seen;
	int          events_sent = 0;
	int          events_done = 0;
	int          results_checked = 0;
	int          mismatches = 0;
	int          cfg_writes = 0;
	int          in_gap = 0;
	int          hold_left = 0;
	int          right_pct = 50;
	logic        offer_held;
	logic        steady = 1'b0;
	logic [TIME_W-1:0] stamp = '0;

	function automatic int draw_pause();
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic knob_view_t step_knob(input logic [2:0] op, input logic [TIME_W-1:0] t,
			input logic jack, input logic usb);
		knob_view_t v;
		logic [TIME_W-1:0] held;
		int sum;
		logic note;
		logic draw;
		note = 1'b0;
		draw = 1'b0;
		if (op == OP_POLL) begin
			if (k_flags[F_AUTO] && (k_flags[F_HP] != jack || k_flags[F_SP] != !jack)) begin
				k_flags[F_HP] = jack;
				k_flags[F_SP] = !jack;
				note = 1'b1;
			end
			if (k_usb != usb) begin
				k_usb = usb;
				note = 1'b1;
			end
		end else if (op <= OP_REFRESH) begin
			case (k_mode)
				MODE_VOLUME: begin
					if (op == OP_LEFT) begin
						sum = int'(k_volume);
						k_volume = (sum <= int'(vol_step)) ? '0 : VOL_W'(sum - int'(vol_step));
						note = 1'b1;
						draw = 1'b1;
					end else if (op == OP_RIGHT) begin
						sum = int'(k_volume) + int'(vol_step);
						k_volume = (sum >= 255) ? VOL_MAX : VOL_W'(sum);
						note = 1'b1;
						draw = 1'b1;
					end else if (op == OP_DOWN) begin
						k_press = t;
					end else if (op == OP_UP) begin
						held = t - k_press;
						if (held > TIME_W'(long_press)) begin
							k_mode = MODE_MENU;
							k_cursor = '0;
						end else begin
							k_mode = MODE_INPUT;
							note = !k_mute;
							k_mute = 1'b1;
							k_cursor = {1'b0, k_source};
						end
						draw = 1'b1;
					end else begin
						draw = 1'b1;
					end
				end
				MODE_INPUT: begin
					if (op == OP_LEFT) begin
						k_cursor = (k_cursor == '0) ? CURSOR_W'(INPUT_CHOICES_DEF - 1) :
							CURSOR_W'(k_cursor - 1);
						draw = 1'b1;
					end else if (op == OP_RIGHT) begin
						k_cursor = CURSOR_W'((k_cursor + 1) % INPUT_CHOICES_DEF);
						draw = 1'b1;
					end else if (op == OP_UP) begin
						// the last choice backs out and keeps the mute
						if (k_cursor < CURSOR_W'(INPUT_CHOICES_DEF - 1)) begin
							note = (k_cursor[1:0] != k_source) || k_mute;
							k_source = k_cursor[1:0];
							k_mute = 1'b0;
						end
						k_mode = MODE_VOLUME;
						draw = 1'b1;
					end
				end
				MODE_MENU: begin
					if (op == OP_LEFT) begin
						k_cursor = (k_cursor == '0) ? CURSOR_W'(MENU_ITEMS_DEF - 1) :
							CURSOR_W'(k_cursor - 1);
						draw = 1'b1;
					end else if (op == OP_RIGHT) begin
						k_cursor = CURSOR_W'((k_cursor + 1) % MENU_ITEMS_DEF);
						draw = 1'b1;
					end else if (op == OP_UP) begin
						case (k_cursor)
							ITEM_AUTO_SWITCH: k_flags[F_AUTO] = !k_flags[F_AUTO];
							ITEM_HEADPHONES: begin
								k_flags[F_AUTO] = 1'b0;
								k_flags[F_HP] = !k_flags[F_HP];
							end
							ITEM_SPEAKERS: begin
								k_flags[F_AUTO] = 1'b0;
								k_flags[F_SP] = !k_flags[F_SP];
							end
							ITEM_AUTO_OFF: k_flags[F_OFF] = !k_flags[F_OFF];
							default: ;
						endcase
						k_mode = MODE_VOLUME;
						draw = 1'b1;
					end
				end
				default: ;
			endcase
		end
		v.mode = k_mode;
		v.cursor = k_cursor;
		v.volume = k_volume;
		v.source = k_source;
		v.muted = k_mute;
		v.auto_sw = k_flags[F_AUTO];
		v.hp = k_flags[F_HP];
		v.sp = k_flags[F_SP];
		v.pwr_save = k_flags[F_OFF];
		v.usb = k_usb;
		v.notify = note;
		v.redraw = draw;
		return v;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch at %0t, result %0d: %s got %h want %h", $realtime,
				results_checked, what, got, want);
		mismatches++;
	endtask

	task automatic compare_view(input knob_view_t got, input knob_view_t want);
		if (got.mode !== want.mode)
			report_mismatch("ui_mode", 32'(got.mode), 32'(want.mode));
		if (got.cursor !== want.cursor)
			report_mismatch("cursor", 32'(got.cursor), 32'(want.cursor));
		if (got.volume !== want.volume)
			report_mismatch("volume", 32'(got.volume), 32'(want.volume));
		if (got.source !== want.source)
			report_mismatch("input_source", 32'(got.source), 32'(want.source));
		if (got.muted !== want.muted)
			report_mismatch("muted", 32'(got.muted), 32'(want.muted));
		if (got.auto_sw !== want.auto_sw)
			report_mismatch("auto_switch_on", 32'(got.auto_sw), 32'(want.auto_sw));
		if (got.hp !== want.hp)
			report_mismatch("headphones_enabled", 32'(got.hp), 32'(want.hp));
		if (got.sp !== want.sp)
			report_mismatch("speakers_enabled", 32'(got.sp), 32'(want.sp));
		if (got.pwr_save !== want.pwr_save)
			report_mismatch("auto_off_on", 32'(got.pwr_save), 32'(want.pwr_save));
		if (got.usb !== want.usb)
			report_mismatch("usb_powered", 32'(got.usb), 32'(want.usb));
		if (got.notify !== want.notify)
			report_mismatch("notify", 32'(got.notify), 32'(want.notify));
		if (got.redraw !== want.redraw)
			report_mismatch("redraw", 32'(got.redraw), 32'(want.redraw));
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			offer_held = in_valid;
			if (in_valid && !in_stall) begin
				expected_views.push_back(step_knob(operation, now_ms, jack_inserted,
					usb_sense_low));
				events_done++;
				offer_held = 1'b0;
			end
			if (!offer_held) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_events.size() > 0) begin
					next_ev = pending_events.pop_front();
					in_valid <= 1'b1;
					operation <= next_ev.op;
					now_ms <= next_ev.stamp;
					jack_inserted <= next_ev.jack;
					usb_sense_low <= next_ev.usb;
					in_gap = draw_pause();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen = '{ui_mode, cursor, volume, input_source, muted, auto_switch_on,
					headphones_enabled, speakers_enabled, auto_off_on, usb_powered,
					notify, redraw};
				if (expected_views.size() == 0)
					report_mismatch("result with nothing pending", 32'(seen), '0);
				else
					compare_view(seen, expected_views.pop_front());
				results_checked++;
				hold_left = draw_pause();
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic push_event(input logic [2:0] op, input logic [TIME_W-1:0] t,
			input logic jack, input logic usb);
		knob_event_t ev;
		ev.op = op;
		ev.stamp = t;
		ev.jack = jack;
		ev.usb = usb;
		pending_events.push_back(ev);
		events_sent++;
	endtask

	task automatic push_turn();
		push_event(($urandom_range(0, 99) < right_pct) ? OP_RIGHT : OP_LEFT, stamp,
			coin(), coin());
	endtask

	// one knob gesture: mostly well-formed press/turn/release sequences
	task automatic push_gesture();
		int pick;
		int r;
		logic [TIME_W-1:0] held;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 7) == 0)
			stamp = $urandom();
		else
			stamp += $urandom_range(1, 3000);
		if (pick < 30) begin
			repeat ($urandom_range(1, 6)) push_turn();
		end else if (pick < 75) begin
			r = $urandom_range(0, 3);
			if (pick < 52)
				held = (r == 0) ? TIME_W'(long_press) : $urandom_range(0, long_press);
			else if (r == 0)
				held = long_press + 1;
			else if (r == 1)
				held = $urandom();
			else
				held = long_press + 1 + $urandom_range(0, 5000);
			push_event(OP_DOWN, stamp, coin(), coin());
			stamp += held;
			push_event(OP_UP, stamp, coin(), coin());
			repeat ($urandom_range(0, 7)) push_turn();
			if ($urandom_range(0, 9) == 0)
				push_event(OP_REFRESH, stamp, coin(), coin());
			push_event(OP_UP, stamp + $urandom_range(0, 500), coin(), coin());
		end else if (pick < 85) begin
			push_event(OP_POLL, stamp, coin(), coin());
		end else if (pick < 90) begin
			push_event(OP_REFRESH, stamp, coin(), coin());
		end else begin
			push_event(3'($urandom_range(0, 7)), $urandom(), coin(), coin());
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_VOLUME_STEP)
			vol_step = data[VSTEP_W-1:0];
		else
			long_press = data;
		cfg_writes++;
	endtask

	task automatic wait_drained();
		while (events_done != events_sent || expected_views.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int step_plan[PHASES];
		int press_plan[PHASES];
		int bias_plan[PHASES];
		int first;
		step_plan = '{127, 1, 1, 127, -1, -1};
		press_plan = '{0, 65535, 0, 65535, -1, -1};
		bias_plan = '{50, 85, 15, 60, 50, 50};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed sequence under the reset settings
		push_event(OP_LEFT, 32'd0, 1'b0, 1'b0);          // floor at zero volume
		push_event(OP_REFRESH, 32'd0, 1'b0, 1'b0);
		push_event(OP_POLL, 32'd0, 1'b1, 1'b1);          // usb latch change
		push_event(OP_SPARE_LO, '1, 1'b1, 1'b1);
		push_event(OP_SPARE_HI, '0, 1'b0, 1'b1);
		push_event(OP_DOWN, 32'hFFFF_FF00, 1'b0, 1'b1);
		push_event(OP_UP, 32'h0000_02E7, 1'b0, 1'b1);    // held 999 across the wrap
		push_event(OP_LEFT, 32'd0, 1'b0, 1'b1);          // cursor wraps to last choice
		push_event(OP_REFRESH, 32'd0, 1'b0, 1'b1);       // ignored in input select
		push_event(OP_DOWN, 32'd0, 1'b0, 1'b1);          // ignored in input select
		push_event(OP_UP, 32'd0, 1'b0, 1'b1);            // cancel, stays muted
		push_event(OP_DOWN, 32'd5000, 1'b0, 1'b1);
		push_event(OP_UP, 32'd6001, 1'b0, 1'b1);         // long press opens settings
		push_event(OP_LEFT, 32'd6001, 1'b0, 1'b1);
		push_event(OP_UP, 32'd6001, 1'b0, 1'b1);         // auto off toggle
		push_event(OP_DOWN, 32'd7000, 1'b0, 1'b1);
		push_event(OP_UP, 32'd8001, 1'b0, 1'b1);
		push_event(OP_RIGHT, 32'd8001, 1'b0, 1'b1);
		push_event(OP_UP, 32'd8001, 1'b0, 1'b1);         // auto switch on
		push_event(OP_POLL, 32'd8001, 1'b0, 1'b0);       // speakers selected
		push_event(OP_POLL, 32'd8002, 1'b1, 1'b0);       // headphones selected
		push_event(OP_DOWN, 32'd9000, 1'b1, 1'b0);
		push_event(OP_UP, 32'd9000, 1'b1, 1'b0);
		push_event(OP_RIGHT, 32'd9000, 1'b1, 1'b0);
		push_event(OP_UP, 32'd9000, 1'b1, 1'b0);         // commit source 1, unmute
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(CFG_VOLUME_STEP, CFG_DATA_W'((step_plan[ph] < 0) ?
				$urandom_range(1, 127) : step_plan[ph]));
			write_reg(CFG_LONG_PRESS_MS, CFG_DATA_W'((press_plan[ph] < 0) ?
				$urandom_range(0, 65535) : press_plan[ph]));
			@(negedge clk);
			steady = (ph == 2 || ph == 5);
			right_pct = bias_plan[ph];
			first = events_sent;
			while (events_sent < first + PHASE_EVENTS)
				push_gesture();
			wait_drained();
		end

		$display("covered %0d knob events and %0d results across %0d register writes",
			events_sent, results_checked, cfg_writes);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d field mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
